// File: hdl/mtrr_pkg.sv
// ----------------------------------------------------------------------------
// mtrr_pkg
// Shared constants and types for the memory type resolver.
// ----------------------------------------------------------------------------
package mtrr_pkg;

	localparam int MAX_ENTRIES    = 8;
	localparam int WORD_W         = 64;
	localparam int PAGE_LSB       = 12;
	localparam int FIELD_W        = WORD_W - PAGE_LSB;
	localparam int TYPE_W         = 8;
	localparam int SLOT_W         = 3;
	localparam int CNT_W          = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 8;
	localparam int MASK_VALID_BIT = 11;

	localparam logic [TYPE_W-1:0] TYPE_UC = 8'd0;
	localparam logic [TYPE_W-1:0] TYPE_WT = 8'd4;
	localparam logic [TYPE_W-1:0] TYPE_WB = 8'd6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEFAULT_ENABLE = 2'd0,
		CFG_DEFAULT_TYPE   = 2'd1,
		CFG_ACTIVE_ENTRIES = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic               enable;
		logic [TYPE_W-1:0]  dtype;
		logic [CNT_W-1:0]   count;
	} cfg_t;

	// key holds the base for a write word and the address for a lookup word
	typedef struct packed {
		logic               is_write;
		logic [SLOT_W-1:0]  slot;
		logic [FIELD_W-1:0] key;
		logic [TYPE_W-1:0]  etype;
		logic [FIELD_W-1:0] mask;
		logic               evalid;
	} cmd_t;

	typedef struct packed {
		logic [TYPE_W-1:0]  mem_type;
		logic               type_valid;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// File: hdl/mtrr_front.sv
// ----------------------------------------------------------------------------
// mtrr_front
// Input stage: accepts words, splits them into write or lookup commands.
// ----------------------------------------------------------------------------
module mtrr_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  mode,
	input  logic [mtrr_pkg::SLOT_W-1:0]           entry_index,
	input  logic [mtrr_pkg::WORD_W-1:0]           entry_base,
	input  logic [mtrr_pkg::WORD_W-1:0]           entry_mask,
	input  logic [mtrr_pkg::WORD_W-1:0]           address,
	output logic                                  cmd_push,
	output mtrr_pkg::cmd_t                        cmd,
	input  mtrr_pkg::qstat_t                      q_stat
);

	logic            v_s1;
	mtrr_pkg::cmd_t  cmd_s1;
	mtrr_pkg::cmd_t  dec;
	logic            in_ready;
	logic            accept;

	assign in_ready = !v_s1 || !q_stat.full;
	assign accept   = push && in_ready;
	assign full     = !in_ready;
	assign cmd_push = v_s1;
	assign cmd      = cmd_s1;

	always_comb begin
		dec.is_write = !mode;
		dec.slot     = entry_index;
		dec.key      = mode ? address[mtrr_pkg::WORD_W-1:mtrr_pkg::PAGE_LSB]
		                    : entry_base[mtrr_pkg::WORD_W-1:mtrr_pkg::PAGE_LSB];
		dec.etype    = entry_base[mtrr_pkg::TYPE_W-1:0];
		dec.mask     = entry_mask[mtrr_pkg::WORD_W-1:mtrr_pkg::PAGE_LSB];
		dec.evalid   = entry_mask[mtrr_pkg::MASK_VALID_BIT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && q_stat.full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= dec;
		end
	end

endmodule

// File: hdl/mtrr_cmd_q.sv
// ----------------------------------------------------------------------------
// mtrr_cmd_q
// Two-entry command queue between the front and back sections.
// ----------------------------------------------------------------------------
module mtrr_cmd_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  mtrr_pkg::cmd_t    wr_data,
	input  logic              rd,
	output mtrr_pkg::cmd_t    rd_data,
	output mtrr_pkg::qstat_t  stat
);

	mtrr_pkg::cmd_t  mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: hdl/mtrr_back.sv
// ----------------------------------------------------------------------------
// mtrr_back
// Range table, parallel match and type resolution, result queue.
// ----------------------------------------------------------------------------
module mtrr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mtrr_pkg::cfg_t               cfg,
	input  mtrr_pkg::cmd_t               cmd,
	input  mtrr_pkg::qstat_t             q_stat,
	output logic                         cmd_pop,
	input  logic                         pop,
	output logic                         empty,
	output logic [mtrr_pkg::TYPE_W-1:0]  mem_type,
	output logic                         type_valid
);

	logic [mtrr_pkg::FIELD_W-1:0] base_q  [mtrr_pkg::MAX_ENTRIES];
	logic [mtrr_pkg::FIELD_W-1:0] mask_q  [mtrr_pkg::MAX_ENTRIES];
	logic [mtrr_pkg::TYPE_W-1:0]  type_q  [mtrr_pkg::MAX_ENTRIES];
	logic [mtrr_pkg::MAX_ENTRIES-1:0] valid_q;

	logic [mtrr_pkg::MAX_ENTRIES-1:0] hit;
	logic [mtrr_pkg::TYPE_W-1:0]      first_type;
	logic                             saw_uc;
	logic                             saw_wt;
	logic                             saw_wb;
	mtrr_pkg::res_t                   res;

	mtrr_pkg::res_t  out_q [2];
	logic            owr_ptr_q;
	logic            ord_ptr_q;
	logic [1:0]      ocnt_q;
	logic            out_pop;
	logic            room;
	logic            res_push;
	logic            tbl_wr;

	assign empty    = (ocnt_q == 2'd0);
	assign out_pop  = pop && !empty;
	assign room     = (ocnt_q != 2'd2) || out_pop;
	assign cmd_pop  = !q_stat.empty && (cmd.is_write || room);
	assign res_push = cmd_pop && !cmd.is_write;
	assign tbl_wr   = cmd_pop && cmd.is_write;

	assign mem_type   = out_q[ord_ptr_q].mem_type;
	assign type_valid = out_q[ord_ptr_q].type_valid;

	always_comb begin
		first_type = mtrr_pkg::TYPE_UC;
		saw_uc     = 1'b0;
		saw_wt     = 1'b0;
		saw_wb     = 1'b0;
		for (int k = 0; k < mtrr_pkg::MAX_ENTRIES; k++) begin
			hit[k] = (32'(cfg.count) > k) && valid_q[k] && (|mask_q[k])
			         && (((cmd.key ^ base_q[k]) & mask_q[k]) == '0);
			saw_uc = saw_uc || (hit[k] && (type_q[k] == mtrr_pkg::TYPE_UC));
			saw_wt = saw_wt || (hit[k] && (type_q[k] == mtrr_pkg::TYPE_WT));
			saw_wb = saw_wb || (hit[k] && (type_q[k] == mtrr_pkg::TYPE_WB));
		end
		for (int k = mtrr_pkg::MAX_ENTRIES - 1; k >= 0; k--) begin
			if (hit[k]) begin
				first_type = type_q[k];
			end
		end
		if (!cfg.enable) begin
			res.mem_type   = mtrr_pkg::TYPE_UC;
			res.type_valid = 1'b0;
		end else begin
			res.type_valid = 1'b1;
			if (hit == '0) begin
				res.mem_type = cfg.dtype;
			end else if (saw_uc) begin
				res.mem_type = mtrr_pkg::TYPE_UC;
			end else if (saw_wt && saw_wb) begin
				res.mem_type = mtrr_pkg::TYPE_WT;
			end else begin
				res.mem_type = first_type;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < mtrr_pkg::MAX_ENTRIES; k++) begin
				base_q[k] <= '0;
				mask_q[k] <= '0;
				type_q[k] <= '0;
			end
			valid_q <= '0;
		end else if (tbl_wr) begin
			for (int k = 0; k < mtrr_pkg::MAX_ENTRIES; k++) begin
				if (32'(cmd.slot) == k) begin
					base_q[k]  <= cmd.key;
					mask_q[k]  <= cmd.mask;
					type_q[k]  <= cmd.etype;
					valid_q[k] <= cmd.evalid;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= 1'b0;
			ord_ptr_q <= 1'b0;
			ocnt_q    <= 2'd0;
		end else begin
			if (res_push) begin
				owr_ptr_q <= !owr_ptr_q;
			end
			if (out_pop) begin
				ord_ptr_q <= !ord_ptr_q;
			end
			case ({res_push, out_pop})
				2'b10:   ocnt_q <= ocnt_q + 2'd1;
				2'b01:   ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q[owr_ptr_q] <= res;
		end
	end

endmodule

// File: hdl/mtrr_memory_type_resolver.sv
// ----------------------------------------------------------------------------
// mtrr_memory_type_resolver
// Variable memory-range type lookup with a front decode stage, a command
// queue and a back section holding the range table.
// ----------------------------------------------------------------------------
// Path: front stage register, command queue, range match, result queue.
// Throughput: one word per cycle while full is low; all table entries compare
//   in parallel in the back section, and the two-entry result queue absorbs
//   a pop stall.
// Reset: arst_n clears config registers, table entries and both queues;
//   the block is ready to take words as soon as reset is released.
module mtrr_memory_type_resolver (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  mode,
	input  logic [mtrr_pkg::SLOT_W-1:0]           entry_index,
	input  logic [mtrr_pkg::WORD_W-1:0]           entry_base,
	input  logic [mtrr_pkg::WORD_W-1:0]           entry_mask,
	input  logic [mtrr_pkg::WORD_W-1:0]           address,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [mtrr_pkg::TYPE_W-1:0]           mem_type,
	output logic                                  type_valid,
	input  logic                                  cfg_we,
	input  logic [mtrr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mtrr_pkg::CFG_DATA_W-1:0]       cfg_data
);

	mtrr_pkg::cfg_t    cfg_q;
	logic              cmd_push;
	mtrr_pkg::cmd_t    cmd_in;
	mtrr_pkg::cmd_t    cmd_head;
	mtrr_pkg::qstat_t  q_stat;
	logic              cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (mtrr_pkg::cfg_idx_t'(cfg_index))
				mtrr_pkg::CFG_DEFAULT_ENABLE: cfg_q.enable <= cfg_data[0];
				mtrr_pkg::CFG_DEFAULT_TYPE:   cfg_q.dtype  <= cfg_data;
				mtrr_pkg::CFG_ACTIVE_ENTRIES: cfg_q.count  <= cfg_data[mtrr_pkg::CNT_W-1:0];
				default:                      cfg_q        <= cfg_q;
			endcase
		end
	end

	mtrr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.entry_index (entry_index),
		.entry_base  (entry_base),
		.entry_mask  (entry_mask),
		.address     (address),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in),
		.q_stat      (q_stat)
	);

	mtrr_cmd_q u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.wr_data (cmd_in),
		.rd      (cmd_pop),
		.rd_data (cmd_head),
		.stat    (q_stat)
	);

	mtrr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd_head),
		.q_stat     (q_stat),
		.cmd_pop    (cmd_pop),
		.pop        (pop),
		.empty      (empty),
		.mem_type   (mem_type),
		.type_valid (type_valid)
	);

`ifndef SYNTHESIS
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result queue not empty after reset");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !type_valid) |-> (mem_type == mtrr_pkg::TYPE_UC))
		else $error("invalid word carries nonzero type");

	a_cmdq_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("command queue full and empty");

	a_pop_only_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !q_stat.empty)
		else $error("command popped from empty queue");
`endif

endmodule
